[rtl/pdss_pkg.sv]
// Package for the power domain suspend sequencer.
// Holds field widths, op, status and phase codes, and the sequencer state types.
// No dependencies.
package pdss_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int OP_W      = 3;
    localparam int SLOT_W    = 4;
    localparam int STATUS_W  = 3;
    localparam int PHASE_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER   = 3'd0,
        OP_UNREGISTER = 3'd1,
        OP_SUSPEND    = 3'd2,
        OP_RESUME     = 3'd3,
        OP_ACK        = 3'd4,
        OP_QUERY      = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_NO_FREE   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FAILED    = 3'd4,
        ST_STRAY_ACK = 3'd5
    } t_status;

    typedef enum logic [PHASE_W-1:0] {
        PH_RUN        = 3'd0,
        PH_SUSPENDING = 3'd1,
        PH_SUSPENDED  = 3'd2,
        PH_RESUMING   = 3'd3,
        PH_FAILED     = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_EXEC,
        S_SWEEP,
        S_SCAN_RD,
        S_SCAN_CK
    } t_state;

    // what a slot scan looks for
    typedef enum logic [1:0] {
        SC_FREE,   // lowest unused slot, upward
        SC_UP,     // next used slot, upward
        SC_DOWN,   // next used slot, downward
        SC_ROLL    // next suspended slot, downward
    } t_scan;

endpackage

[rtl/power_domain_suspend_sequencer.sv]
// Power domain suspend sequencer: slot table, system phase machine, slot scanner.
// Depends on pdss_pkg.
//
//  channel   | handshake          | fields
//  ----------+--------------------+---------------------------------------------
//  request   | start / busy       | i_op, i_slot, i_ack_ok
//  result    | o_valid (strobe)   | o_status, o_assigned_slot, o_cmd_valid,
//            |                    | o_cmd_resume, o_cmd_slot, o_seq_done,
//            |                    | o_system_phase_out, o_slot_phase_out
//
// A request is taken when start is high and busy low; its result strobes once, busy is
// low in that cycle, so the next request can be taken at the same edge.
// Busy, query, unregister and ack-finish answers: strobe from the exec state, after prep.
// Register and ack scans walk the slots one at a time, a read state then a check state per slot.
// Start suspend/resume sweeps every slot once to mark phases, then strobes.
// The single-port phase memory and the one shared slot scanner set this pacing.
// Reset (i_rst_n low, synchronous) clears all slots and returns the system to running.
module power_domain_suspend_sequencer #(
    parameter int SLOTS = pdss_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pdss_pkg::OP_W-1:0]       i_op,
    input  logic [pdss_pkg::SLOT_W-1:0]     i_slot,
    input  logic                            i_ack_ok,
    output logic                            o_valid,
    output logic [pdss_pkg::STATUS_W-1:0]   o_status,
    output logic [pdss_pkg::SLOT_W-1:0]     o_assigned_slot,
    output logic                            o_cmd_valid,
    output logic                            o_cmd_resume,
    output logic [pdss_pkg::SLOT_W-1:0]     o_cmd_slot,
    output logic                            o_seq_done,
    output logic [pdss_pkg::PHASE_W-1:0]    o_system_phase_out,
    output logic [pdss_pkg::PHASE_W-1:0]    o_slot_phase_out
);
    import pdss_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // sequencer and table state
    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_used, n_used;
    t_phase              r_sys, n_sys;
    logic [IDX_W-1:0]    r_cur, n_cur;
    logic                r_rb, n_rb;
    logic                r_rbf, n_rbf;

    // latched request and scanner
    t_op                 r_op, n_op;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_ok, n_ok;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_live, n_live;
    t_scan               r_ctx, n_ctx;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_hit, n_hit;

    // result registers
    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [SLOT_W-1:0]   r_assigned, n_assigned;
    logic                r_cmd_valid, n_cmd_valid;
    logic                r_cmd_resume, n_cmd_resume;
    logic [SLOT_W-1:0]   r_cmd_slot, n_cmd_slot;
    logic                r_done, n_done;
    t_phase              r_out_sys, n_out_sys;
    t_phase              r_slot_ph, n_slot_ph;

    // phase memory
    t_phase              mem [SLOTS];
    t_phase              r_rd;
    logic                we;
    t_phase              wdata;

    // decode
    logic                idx_ok, idx_used, idx_first, idx_last;
    logic                cur_first, cur_last, slot_ok;
    logic                scan_up, scan_cond, scan_hit, scan_end;
    logic                exec_sweep, exec_scan;
    logic                sw_found;
    logic [IDX_W-1:0]    sw_hit;

    always_comb begin
        idx_ok    = (32'(r_idx) < SLOTS);
        idx_used  = idx_ok && r_used[r_idx];
        idx_first = (r_idx == '0);
        idx_last  = (32'(r_idx) == SLOTS - 1);
        cur_first = (r_cur == '0);
        cur_last  = (32'(r_cur) == SLOTS - 1);
        slot_ok   = (32'(r_slot) < SLOTS);
        scan_up   = (r_ctx == SC_FREE) || (r_ctx == SC_UP);
        unique case (r_ctx)
            SC_FREE: scan_cond = idx_ok && !idx_used;
            SC_UP:   scan_cond = idx_used;
            SC_DOWN: scan_cond = idx_used;
            SC_ROLL: scan_cond = idx_used && (r_rd == PH_SUSPENDED);
        endcase
        scan_hit  = r_live && scan_cond;
        scan_end  = scan_hit || !r_live || (scan_up ? idx_last : idx_first);

        exec_sweep = 1'b0;
        exec_scan  = 1'b0;
        unique case (r_op)
            OP_REGISTER: exec_scan  = (r_sys == PH_RUN);
            OP_SUSPEND:  exec_sweep = (r_sys == PH_RUN);
            OP_RESUME:   exec_sweep = (r_sys == PH_SUSPENDED);
            OP_ACK:      exec_scan  = (r_sys == PH_SUSPENDING) ||
                                      ((r_sys == PH_RESUMING) && r_ok);
            default:     ;
        endcase

        // suspend keeps the lowest used slot, resume the highest
        sw_found = r_found;
        sw_hit   = r_hit;
        if (idx_used && (r_op == OP_RESUME || !r_found)) begin
            sw_found = 1'b1;
            sw_hit   = r_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (start) n_state = S_PREP;
            S_PREP:    n_state = S_EXEC;
            S_EXEC:    n_state = exec_sweep ? S_SWEEP : (exec_scan ? S_SCAN_RD : S_IDLE);
            S_SWEEP:   if (idx_last) n_state = S_IDLE;
            S_SCAN_RD: n_state = S_SCAN_CK;
            S_SCAN_CK: n_state = scan_end ? S_IDLE : S_SCAN_RD;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_used       = r_used;
        n_sys        = r_sys;
        n_cur        = r_cur;
        n_rb         = r_rb;
        n_rbf        = r_rbf;
        n_op         = r_op;
        n_slot       = r_slot;
        n_ok         = r_ok;
        n_idx        = r_idx;
        n_live       = r_live;
        n_ctx        = r_ctx;
        n_found      = r_found;
        n_hit        = r_hit;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_assigned   = r_assigned;
        n_cmd_valid  = r_cmd_valid;
        n_cmd_resume = r_cmd_resume;
        n_cmd_slot   = r_cmd_slot;
        n_done       = r_done;
        n_slot_ph    = r_slot_ph;
        we           = 1'b0;
        wdata        = PH_RUN;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = t_op'(i_op);
                    n_slot = i_slot;
                    n_ok   = i_ack_ok;
                    n_idx  = (t_op'(i_op) == OP_ACK) ? r_cur : IDX_W'(i_slot);
                end
            end
            S_EXEC: begin
                n_status     = ST_OK;
                n_assigned   = '0;
                n_cmd_valid  = 1'b0;
                n_cmd_resume = 1'b0;
                n_cmd_slot   = '0;
                n_done       = 1'b0;
                n_slot_ph    = PH_RUN;
                n_valid      = !(exec_sweep || exec_scan);
                unique case (r_op)
                    OP_REGISTER: begin
                        if (r_sys != PH_RUN) begin
                            n_status = ST_BUSY;
                        end else begin
                            n_ctx  = SC_FREE;
                            n_idx  = '0;
                            n_live = 1'b1;
                        end
                    end
                    OP_UNREGISTER: begin
                        if (!slot_ok || !idx_used) begin
                            n_status = ST_NOT_FOUND;
                        end else if (r_sys != PH_RUN ||
                                     (r_rd != PH_RUN && r_rd != PH_FAILED)) begin
                            n_status = ST_BUSY;
                        end else begin
                            n_used[r_idx] = 1'b0;
                        end
                    end
                    OP_SUSPEND, OP_RESUME: begin
                        if (!exec_sweep) begin
                            n_status = ST_BUSY;
                        end else begin
                            if (r_op == OP_SUSPEND) begin
                                n_rb  = 1'b0;
                                n_rbf = 1'b0;
                            end
                            n_idx   = '0;
                            n_found = 1'b0;
                        end
                    end
                    OP_ACK: begin
                        n_idx = r_cur - IDX_W'(1);
                        n_live = !cur_first;
                        if (r_sys == PH_SUSPENDING && !r_rb) begin
                            we = 1'b1;
                            if (r_ok) begin
                                wdata  = PH_SUSPENDED;
                                n_ctx  = SC_UP;
                                n_idx  = r_cur + IDX_W'(1);
                                n_live = !cur_last;
                            end else begin
                                wdata = PH_FAILED;
                                n_rb  = 1'b1;
                                n_rbf = 1'b0;
                                n_ctx = SC_ROLL;
                            end
                        end else if (r_sys == PH_SUSPENDING) begin
                            we    = 1'b1;
                            wdata = r_ok ? PH_RUN : PH_FAILED;
                            if (!r_ok) n_rbf = 1'b1;
                            n_ctx = SC_ROLL;
                        end else if (r_sys == PH_RESUMING) begin
                            we = 1'b1;
                            if (!r_ok) begin
                                wdata    = PH_FAILED;
                                n_sys    = PH_FAILED;
                                n_status = ST_FAILED;
                                n_done   = 1'b1;
                            end else begin
                                wdata = PH_RUN;
                                n_ctx = SC_DOWN;
                            end
                        end else begin
                            n_status = ST_STRAY_ACK;
                        end
                    end
                    OP_QUERY: begin
                        n_slot_ph = (slot_ok && idx_used) ? r_rd : PH_FAILED;
                    end
                    default: ;
                endcase
            end
            S_SWEEP: begin
                if (idx_used) begin
                    we    = 1'b1;
                    wdata = (r_op == OP_SUSPEND) ? PH_SUSPENDING : PH_RESUMING;
                end
                n_found = sw_found;
                n_hit   = sw_hit;
                n_idx   = r_idx + IDX_W'(1);
                if (idx_last) begin
                    n_valid = 1'b1;
                    if (!sw_found) begin
                        n_sys  = (r_op == OP_SUSPEND) ? PH_SUSPENDED : PH_RUN;
                        n_done = 1'b1;
                    end else begin
                        n_sys        = (r_op == OP_SUSPEND) ? PH_SUSPENDING : PH_RESUMING;
                        n_cur        = sw_hit;
                        n_cmd_valid  = 1'b1;
                        n_cmd_resume = (r_op == OP_RESUME);
                        n_cmd_slot   = SLOT_W'(sw_hit);
                    end
                end
            end
            S_SCAN_CK: begin
                if (!scan_end) begin
                    n_idx = scan_up ? r_idx + IDX_W'(1) : r_idx - IDX_W'(1);
                end else begin
                    n_valid = 1'b1;
                    unique case (r_ctx)
                        SC_FREE: begin
                            if (scan_hit) begin
                                n_used[r_idx] = 1'b1;
                                we            = 1'b1;
                                wdata         = PH_RUN;
                                n_assigned    = SLOT_W'(r_idx);
                            end else begin
                                n_status = ST_NO_FREE;
                            end
                        end
                        SC_UP, SC_DOWN: begin
                            if (scan_hit) begin
                                n_cur        = r_idx;
                                n_cmd_valid  = 1'b1;
                                n_cmd_resume = (r_ctx == SC_DOWN);
                                n_cmd_slot   = SLOT_W'(r_idx);
                            end else begin
                                n_sys  = (r_ctx == SC_UP) ? PH_SUSPENDED : PH_RUN;
                                n_done = 1'b1;
                            end
                        end
                        SC_ROLL: begin
                            n_status = r_ok ? ST_OK : ST_FAILED;
                            if (scan_hit) begin
                                n_cur        = r_idx;
                                n_cmd_valid  = 1'b1;
                                n_cmd_resume = 1'b1;
                                n_cmd_slot   = SLOT_W'(r_idx);
                            end else begin
                                n_sys    = r_rbf ? PH_FAILED : PH_RUN;
                                n_rb     = 1'b0;
                                n_done   = 1'b1;
                                n_status = ST_FAILED;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase

        n_out_sys = n_valid ? n_sys : r_out_sys;
    end

    // phase memory: one write, one registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (we) mem[r_idx] <= wdata;
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_sys   <= PH_RUN;
            r_cur   <= '0;
            r_rb    <= 1'b0;
            r_rbf   <= 1'b0;
            r_ctx   <= SC_FREE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_sys   <= n_sys;
            r_cur   <= n_cur;
            r_rb    <= n_rb;
            r_rbf   <= n_rbf;
            r_ctx   <= n_ctx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_slot       <= n_slot;
        r_ok         <= n_ok;
        r_idx        <= n_idx;
        r_live       <= n_live;
        r_found      <= n_found;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_assigned   <= n_assigned;
        r_cmd_valid  <= n_cmd_valid;
        r_cmd_resume <= n_cmd_resume;
        r_cmd_slot   <= n_cmd_slot;
        r_done       <= n_done;
        r_out_sys    <= n_out_sys;
        r_slot_ph    <= n_slot_ph;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_assigned_slot    = r_assigned;
    assign o_cmd_valid        = r_cmd_valid && r_valid;
    assign o_cmd_resume       = r_cmd_resume;
    assign o_cmd_slot         = r_cmd_slot;
    assign o_seq_done         = r_done && r_valid;
    assign o_system_phase_out = r_out_sys;
    assign o_slot_phase_out   = r_slot_ph;

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_cmd_in_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> (o_system_phase_out == PH_SUSPENDING ||
                         o_system_phase_out == PH_RESUMING) && !o_seq_done)
        else $error("domain command outside a running sequence");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted request did not make the block busy");

    a_rollback_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rb |-> r_sys == PH_SUSPENDING)
        else $error("rollback active outside suspending");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for power_domain_suspend_sequencer: directed and random requests,
// each result checked against an in-bench model of the slot table and phases.
// Depends on pdss_pkg and the sequencer RTL.
module tb;
    import pdss_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [2:0] status;
        logic [3:0] assigned;
        logic       cmd_v;
        logic       cmd_r;
        logic [3:0] cmd_s;
        logic       done;
        logic [2:0] sys;
        logic [2:0] sp;
    } t_seq_result;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       start    = 1'b0;
    logic [2:0] i_op     = '0;
    logic [3:0] i_slot   = '0;
    logic       i_ack_ok = 1'b0;
    logic       busy;
    logic       o_valid;
    logic [2:0] o_status;
    logic [3:0] o_assigned_slot;
    logic       o_cmd_valid;
    logic       o_cmd_resume;
    logic [3:0] o_cmd_slot;
    logic       o_seq_done;
    logic [2:0] o_system_phase_out;
    logic [2:0] o_slot_phase_out;

    // model of the sequencer
    logic   dom_used [SLOTS];
    t_phase dom_phase [SLOTS];
    t_phase sys_phase;
    int     cur_slot;
    logic   rolling_back;
    logic   rb_failed;

    t_seq_result pending_results[$];
    int          errors;
    int          stall_cycles;
    logic        idle_en = 1'b1;

    power_domain_suspend_sequencer #(.SLOTS(SLOTS)) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_op               (i_op),
        .i_slot             (i_slot),
        .i_ack_ok           (i_ack_ok),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_assigned_slot    (o_assigned_slot),
        .o_cmd_valid        (o_cmd_valid),
        .o_cmd_resume       (o_cmd_resume),
        .o_cmd_slot         (o_cmd_slot),
        .o_seq_done         (o_seq_done),
        .o_system_phase_out (o_system_phase_out),
        .o_slot_phase_out   (o_slot_phase_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        errors = 0;
        for (int i = 0; i < SLOTS; i++) begin
            dom_used[i]  = 1'b0;
            dom_phase[i] = PH_RUN;
        end
        sys_phase    = PH_RUN;
        cur_slot     = 0;
        rolling_back = 1'b0;
        rb_failed    = 1'b0;
    end

    function automatic int find_up(int from);
        for (int i = from; i < SLOTS; i++)
            if (dom_used[i]) return i;
        return SLOTS;
    endfunction

    function automatic int find_down(int below, logic need_suspended);
        for (int i = below - 1; i >= 0; i--)
            if (dom_used[i] && (!need_suspended || dom_phase[i] == PH_SUSPENDED)) return i;
        return SLOTS;
    endfunction

    function automatic t_seq_result sequencer_step(logic [2:0] op, logic [3:0] sl, logic ok);
        t_seq_result r;
        int          n;
        logic        roll;
        r.status   = ST_OK;
        r.assigned = '0;
        r.cmd_v    = 1'b0;
        r.cmd_r    = 1'b0;
        r.cmd_s    = '0;
        r.done     = 1'b0;
        r.sp       = PH_RUN;
        roll       = 1'b0;
        case (op)
            OP_REGISTER: begin
                if (sys_phase != PH_RUN) begin
                    r.status = ST_BUSY;
                end else begin
                    n = SLOTS;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!dom_used[i]) n = i;
                    if (n >= SLOTS) begin
                        r.status = ST_NO_FREE;
                    end else begin
                        dom_used[n]  = 1'b1;
                        dom_phase[n] = PH_RUN;
                        r.assigned   = n[3:0];
                    end
                end
            end
            OP_UNREGISTER: begin
                if (!dom_used[sl]) begin
                    r.status = ST_NOT_FOUND;
                end else if (sys_phase != PH_RUN ||
                             (dom_phase[sl] != PH_RUN && dom_phase[sl] != PH_FAILED)) begin
                    r.status = ST_BUSY;
                end else begin
                    dom_used[sl] = 1'b0;
                end
            end
            OP_SUSPEND: begin
                if (sys_phase != PH_RUN) begin
                    r.status = ST_BUSY;
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (dom_used[i]) dom_phase[i] = PH_SUSPENDING;
                    rolling_back = 1'b0;
                    rb_failed    = 1'b0;
                    n = find_up(0);
                    if (n >= SLOTS) begin
                        sys_phase = PH_SUSPENDED;
                        r.done    = 1'b1;
                    end else begin
                        sys_phase = PH_SUSPENDING;
                        cur_slot  = n;
                        r.cmd_v   = 1'b1;
                        r.cmd_s   = n[3:0];
                    end
                end
            end
            OP_RESUME: begin
                if (sys_phase != PH_SUSPENDED) begin
                    r.status = ST_BUSY;
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (dom_used[i]) dom_phase[i] = PH_RESUMING;
                    n = find_down(SLOTS, 1'b0);
                    if (n >= SLOTS) begin
                        sys_phase = PH_RUN;
                        r.done    = 1'b1;
                    end else begin
                        sys_phase = PH_RESUMING;
                        cur_slot  = n;
                        r.cmd_v   = 1'b1;
                        r.cmd_r   = 1'b1;
                        r.cmd_s   = n[3:0];
                    end
                end
            end
            OP_ACK: begin
                if (sys_phase == PH_SUSPENDING && !rolling_back) begin
                    if (ok) begin
                        dom_phase[cur_slot] = PH_SUSPENDED;
                        n = find_up(cur_slot + 1);
                        if (n >= SLOTS) begin
                            sys_phase = PH_SUSPENDED;
                            r.done    = 1'b1;
                        end else begin
                            cur_slot = n;
                            r.cmd_v  = 1'b1;
                            r.cmd_s  = n[3:0];
                        end
                    end else begin
                        dom_phase[cur_slot] = PH_FAILED;
                        r.status     = ST_FAILED;
                        rolling_back = 1'b1;
                        rb_failed    = 1'b0;
                        roll         = 1'b1;
                    end
                end else if (sys_phase == PH_SUSPENDING) begin
                    dom_phase[cur_slot] = ok ? PH_RUN : PH_FAILED;
                    if (!ok) rb_failed = 1'b1;
                    roll = 1'b1;
                end else if (sys_phase == PH_RESUMING) begin
                    if (!ok) begin
                        dom_phase[cur_slot] = PH_FAILED;
                        sys_phase = PH_FAILED;
                        r.status  = ST_FAILED;
                        r.done    = 1'b1;
                    end else begin
                        dom_phase[cur_slot] = PH_RUN;
                        n = find_down(cur_slot, 1'b0);
                        if (n >= SLOTS) begin
                            sys_phase = PH_RUN;
                            r.done    = 1'b1;
                        end else begin
                            cur_slot = n;
                            r.cmd_v  = 1'b1;
                            r.cmd_r  = 1'b1;
                            r.cmd_s  = n[3:0];
                        end
                    end
                end else begin
                    r.status = ST_STRAY_ACK;
                end
                // rollback: resume next suspended slot below, or finish
                if (roll) begin
                    if (!ok) r.status = ST_FAILED;
                    n = find_down(cur_slot, 1'b1);
                    if (n >= SLOTS) begin
                        sys_phase    = rb_failed ? PH_FAILED : PH_RUN;
                        rolling_back = 1'b0;
                        r.done       = 1'b1;
                        r.status     = ST_FAILED;
                    end else begin
                        cur_slot = n;
                        r.cmd_v  = 1'b1;
                        r.cmd_r  = 1'b1;
                        r.cmd_s  = n[3:0];
                    end
                end
            end
            OP_QUERY: begin
                r.sp = dom_used[sl] ? dom_phase[sl] : PH_FAILED;
            end
            default: ;
        endcase
        r.sys = sys_phase;
        return r;
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [3:0] sl, input logic ok);
        if (idle_en && $urandom_range(99) < 30) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy);
            repeat ($urandom_range(0, 14)) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_op     <= op;
        i_slot   <= sl;
        i_ack_ok <= ok;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(sequencer_step(op, sl, ok));
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [3:0] pick_slot(int used_pct);
        int used_list[$];
        for (int i = 0; i < SLOTS; i++)
            if (dom_used[i]) used_list.push_back(i);
        if (used_list.size() != 0 && $urandom_range(99) < used_pct)
            return 4'(used_list[$urandom_range(used_list.size() - 1)]);
        return 4'($urandom);
    endfunction

    task automatic test_empty_table();
        send_request(OP_QUERY, 4'd0, 1'b0);
        send_request(OP_ACK, 4'd9, 1'b1);
        send_request(3'd6, 4'd15, 1'b1);
        send_request(3'd7, 4'd5, 1'b0);
        send_request(OP_SUSPEND, 4'd0, 1'b0);
        send_request(OP_REGISTER, 4'd0, 1'b0);
        send_request(OP_UNREGISTER, 4'd3, 1'b0);
        send_request(OP_RESUME, 4'd0, 1'b0);
        send_request(OP_RESUME, 4'd0, 1'b0);
    endtask

    task automatic test_suspend_rollback();
        repeat (3) send_request(OP_REGISTER, 4'd0, 1'b0);
        send_request(OP_SUSPEND, 4'd0, 1'b0);
        send_request(OP_UNREGISTER, 4'd0, 1'b0);
        send_request(OP_QUERY, 4'd0, 1'b0);
        send_request(OP_ACK, 4'd0, 1'b1);
        send_request(OP_ACK, 4'd0, 1'b0);
        send_request(OP_ACK, 4'd0, 1'b1);
        send_request(OP_QUERY, 4'd2, 1'b0);
        send_request(OP_UNREGISTER, 4'd2, 1'b0);
        send_request(OP_UNREGISTER, 4'd1, 1'b0);
    endtask

    task automatic test_suspend_resume();
        send_request(OP_SUSPEND, 4'd0, 1'b0);
        send_request(OP_ACK, 4'd0, 1'b1);
        send_request(OP_ACK, 4'd0, 1'b1);
        send_request(OP_RESUME, 4'd0, 1'b0);
        send_request(OP_ACK, 4'd0, 1'b1);
        send_request(OP_ACK, 4'd0, 1'b1);
    endtask

    task automatic test_random(input int n_items);
        int         k;
        int         r;
        int         reg_pct;
        logic [2:0] op;
        logic [3:0] sl;
        logic       ok;
        k = 0;
        while (k < n_items) begin
            idle_en = !(k >= 500 && k < 800);
            case ((k / 120) % 3)
                0:       reg_pct = 65;
                1:       reg_pct = 40;
                default: reg_pct = 25;
            endcase
            sl = pick_slot(70);
            ok = 1'b1;
            r  = $urandom_range(99);
            if (r < 12) begin
                op = 3'($urandom);
                ok = 1'($urandom);
            end else begin
                r = $urandom_range(99);
                case (sys_phase)
                    PH_RUN: begin
                        if (r < reg_pct)           op = OP_REGISTER;
                        else if (r < reg_pct + 25) op = OP_UNREGISTER;
                        else if (r < reg_pct + 33) op = OP_QUERY;
                        else                       op = OP_SUSPEND;
                    end
                    PH_SUSPENDED: begin
                        if (r < 50)      op = OP_RESUME;
                        else if (r < 70) op = OP_QUERY;
                        else             op = 3'($urandom_range(OP_ACK));
                    end
                    default: begin
                        if (r < 85) op = OP_ACK;
                        else        op = 3'($urandom_range(OP_QUERY));
                        if (sys_phase == PH_SUSPENDING && !rolling_back)
                            ok = ($urandom_range(99) >= 8);
                    end
                endcase
            end
            // failures while resuming or rolling back are terminal, kept for the end
            if (op == OP_ACK && (sys_phase == PH_RESUMING ||
                                 (sys_phase == PH_SUSPENDING && rolling_back)))
                ok = 1'b1;
            send_request(op, sl, ok);
            if (op <= OP_QUERY) k++;
            if (k % 250 == 249 && $urandom_range(3) == 0) wait_all_results();
        end
        idle_en = 1'b1;
    endtask

    task automatic test_terminal_failure();
        int   used_cnt;
        logic via_rollback;
        while (sys_phase != PH_RUN && sys_phase != PH_FAILED) begin
            if (sys_phase == PH_SUSPENDED) send_request(OP_RESUME, 4'd0, 1'b1);
            else                           send_request(OP_ACK, 4'd0, 1'b1);
        end
        used_cnt = 0;
        for (int i = 0; i < SLOTS; i++)
            if (dom_used[i]) used_cnt++;
        if (used_cnt < 2) repeat (2 - used_cnt) send_request(OP_REGISTER, 4'd0, 1'b0);
        via_rollback = 1'($urandom_range(1));
        send_request(OP_SUSPEND, 4'd0, 1'b0);
        if (via_rollback) begin
            send_request(OP_ACK, 4'd0, 1'b1);
            send_request(OP_ACK, 4'd0, 1'b0);
            while (sys_phase == PH_SUSPENDING) send_request(OP_ACK, 4'd0, 1'b0);
        end else begin
            while (sys_phase == PH_SUSPENDING) send_request(OP_ACK, 4'd0, 1'b1);
            send_request(OP_RESUME, 4'd0, 1'b0);
            send_request(OP_ACK, 4'd0, 1'b1);
            while (sys_phase == PH_RESUMING) send_request(OP_ACK, 4'd0, 1'b0);
        end
        send_request(OP_ACK, 4'd0, 1'b1);
        send_request(OP_REGISTER, 4'd0, 1'b0);
        send_request(OP_UNREGISTER, pick_slot(100), 1'b0);
        send_request(OP_SUSPEND, 4'd0, 1'b0);
        send_request(OP_RESUME, 4'd0, 1'b0);
        repeat (4) send_request(OP_QUERY, pick_slot(80), 1'b0);
        send_request(3'd7, 4'd0, 1'b0);
    endtask

    function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_seq_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no request pending");
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("status", e.status, o_status);
                check_field("assigned_slot", e.assigned, o_assigned_slot);
                check_field("cmd_valid", e.cmd_v, o_cmd_valid);
                check_field("cmd_resume", e.cmd_r, o_cmd_resume);
                check_field("cmd_slot", e.cmd_s, o_cmd_slot);
                check_field("seq_done", e.done, o_seq_done);
                check_field("system_phase_out", e.sys, o_system_phase_out);
                check_field("slot_phase_out", e.sp, o_slot_phase_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL power_domain_suspend_sequencer");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_suspend_rollback();
        test_suspend_resume();
        wait_all_results();
        test_random(1400);
        wait_all_results();
        test_terminal_failure();
        wait_all_results();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS power_domain_suspend_sequencer");
        end else begin
            $display("FAIL power_domain_suspend_sequencer");
        end
        $finish;
    end

endmodule
